FILE: sv/dbd_pkg.sv
// Shared types, register indexes and helpers for the dimer Brownian step core.
`default_nettype none
package dbd_pkg;

  // divider: widest magnitude numerator, narrow (coordinate) numerator, counter width
  localparam int DIV_NW = 62;
  localparam int DIV_NN = 34;
  localparam int DIV_CW = 6;

  // root unit: first bit pair of the 64-bit radicand
  localparam int SQRT_TOP = 62;

  localparam logic [2:0] REG_BOX_X       = 3'd0;
  localparam logic [2:0] REG_BOX_Y       = 3'd1;
  localparam logic [2:0] REG_BOX_Z       = 3'd2;
  localparam logic [2:0] REG_WELL_HEIGHT = 3'd3;
  localparam logic [2:0] REG_REST_LENGTH = 3'd4;
  localparam logic [2:0] REG_WELL_WIDTH  = 3'd5;
  localparam logic [2:0] REG_DRIFT_SCALE = 3'd6;
  localparam logic [2:0] REG_NOISE_SCALE = 3'd7;

  localparam logic [30:0] RST_BOX    = 31'd655360;
  localparam logic [30:0] RST_HEIGHT = 31'd65536;
  localparam logic [30:0] RST_REST   = 31'd65536;
  localparam logic [30:0] RST_WIDTH  = 31'd32768;
  localparam logic [30:0] RST_DRIFT  = 31'd655;
  localparam logic [30:0] RST_NOISE  = 31'd9268;

  localparam logic [1:0] REQ_STEP = 2'd0;
  localparam logic [1:0] REQ_BIAS = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV_WAIT, ST_BOND_GO, ST_BOND_SQ, ST_BOND_ACC, ST_SQRT_GO,
    ST_SQRT_WAIT, ST_F0_GO, ST_F0_SQ, ST_F1, ST_S_MUL1, ST_S_MUL2, ST_S_DIV,
    ST_S_STORE, ST_FORCE_MUL, ST_FORCE_GO, ST_FORCE_ST, ST_UPD_D, ST_UPD_N0,
    ST_UPD_N1, ST_UPD_W0, ST_UPD_W1, ST_UPD_W2, ST_BIAS_MUL, ST_BIAS_GO,
    ST_BIAS_ST, ST_E_MUL, ST_E_MUL2, ST_E_FIN, ST_PUSH
  } state_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/dimer_brownian_dynamics_step_core.sv
// Top level: sequencer, multiplier, state and registers of the dimer Brownian step core.
// Usage:
//   Input channel (in_valid/in_ready) carries one request: in_req_type picks a
//   Brownian step (six unit deviates), a bias step (six biases times drift) or a
//   load of the six coordinates; type three just reports the current state.
//   Result channel (out_valid/out_ready) returns both particles' positions, the
//   minimum-image bond length and the double-well energy, one result per request.
//   Configuration: cfg_we writes cfg_data into register cfg_index;
//   write only while no request is in flight.
// Sequencing:
//   One request at a time. All divisions and wraps go through one bit-serial
//   divider (narrow for a coordinate wrap, wide for a quotient) and the bond
//   length through a bit-pair root unit.
// Reset: positions clear to zero, registers take their default values.
// Stall: the finished result sits in the output register; a new request is
//   taken meanwhile and holds in its last state until the output is taken.
`default_nettype none
module dimer_brownian_dynamics_step_core import dbd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_req_type,
  input  wire logic signed [31:0] in_value_a,
  input  wire logic signed [31:0] in_value_b,
  input  wire logic signed [31:0] in_value_c,
  input  wire logic signed [31:0] in_value_d,
  input  wire logic signed [31:0] in_value_e,
  input  wire logic signed [31:0] in_value_f,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_first_x,
  output logic signed [31:0]      out_first_y,
  output logic signed [31:0]      out_first_z,
  output logic signed [31:0]      out_second_x,
  output logic signed [31:0]      out_second_y,
  output logic signed [31:0]      out_second_z,
  output logic [30:0]             out_bond_length,
  output logic [30:0]             out_energy,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0]        HALF_Q = 64'd1 << (FRAC_BITS - 1);

  // product scaled down by one, rounded half away, saturated
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? (~p + 64'd1) : p;
    r   = (mag + HALF_Q) >> FRAC_BITS;
    qround = sat32(p[63] ? -$signed(r) : $signed(r));
  endfunction

  // configuration
  logic [30:0] box_r [3];
  logic [30:0] height_r, rest_r, width_r, dscale_r, nscale_r;

  // sequencer
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       half_r, half_nxt, post_r, post_nxt;

  // datapath
  logic signed [31:0] p0_r [3], p0_nxt [3], p1_r [3], p1_nxt [3];
  logic signed [31:0] v0_r [3], v0_nxt [3], v1_r [3], v1_nxt [3];
  logic signed [31:0] b_r [3], b_nxt [3], f_r [3], f_nxt [3];
  logic [63:0]        sq_r, sq_nxt;
  logic [30:0]        d_r, d_nxt;
  logic signed [31:0] f0_r, f0_nxt, f1_r, f1_nxt, s_r, s_nxt, drift_r, drift_nxt;
  logic signed [63:0] acc_r, acc_nxt, prod_r;
  logic [30:0]        e_r, e_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] o0_r [3], o0_nxt [3], o1_r [3], o1_nxt [3];
  logic [30:0]        obond_r, obond_nxt, oen_r, oen_nxt;

  // shared units
  div_req_t           div_req;
  logic signed [63:0] div_num;
  logic [30:0]        div_den;
  logic               div_done;
  logic signed [31:0] div_quo, div_wrp;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  logic signed [31:0] hs, pr_q;
  logic signed [63:0] u_num, s4_num;
  logic               push_ok;

  assign hs      = $signed({1'b0, height_r});
  assign pr_q    = qround(prod_r);
  assign u_num   = ($signed({33'd0, d_r}) - $signed({33'd0, rest_r})
                   - $signed({33'd0, width_r})) <<< FRAC_BITS;
  assign s4_num  = 64'(sat32(64'(pr_q) <<< 2)) <<< FRAC_BITS;
  assign push_ok = !out_valid_r || out_ready;
  assign mul_p   = mul_a * mul_b;

  dbd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .wrp  (div_wrp)
  );

  dbd_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .n    (sq_r),
    .done (sq_done),
    .root (sq_root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req_type == REQ_BIAS) ? ST_BIAS_MUL : ST_BOND_GO;
        end
      end
      ST_DIV_WAIT:  if (div_done) state_nxt = ret_r;
      ST_BOND_GO: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_BOND_SQ;
      end
      ST_BOND_SQ:   state_nxt = ST_BOND_ACC;
      ST_BOND_ACC:  state_nxt = (idx_r == 2'd2) ? ST_SQRT_GO : ST_BOND_GO;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sq_done) begin
          state_nxt = (!post_r && sq_root == 32'd0) ? ST_UPD_D : ST_F0_GO;
        end
      end
      ST_F0_GO: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_F0_SQ;
      end
      ST_F0_SQ:     state_nxt = ST_F1;
      ST_F1:        state_nxt = post_r ? ST_E_MUL : ST_S_MUL1;
      ST_S_MUL1:    state_nxt = ST_S_MUL2;
      ST_S_MUL2:    state_nxt = ST_S_DIV;
      ST_S_DIV: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_S_STORE;
      end
      ST_S_STORE:   state_nxt = ST_FORCE_MUL;
      ST_FORCE_MUL: state_nxt = ST_FORCE_GO;
      ST_FORCE_GO: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_FORCE_ST;
      end
      ST_FORCE_ST:  state_nxt = (idx_r == 2'd2) ? ST_UPD_D : ST_FORCE_MUL;
      ST_UPD_D:     state_nxt = ST_UPD_N0;
      ST_UPD_N0:    state_nxt = ST_UPD_N1;
      ST_UPD_N1:    state_nxt = ST_UPD_W0;
      ST_UPD_W0: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_UPD_W1;
      end
      ST_UPD_W1: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_UPD_W2;
      end
      ST_UPD_W2:    state_nxt = (idx_r == 2'd2) ? ST_BOND_GO : ST_UPD_D;
      ST_BIAS_MUL:  state_nxt = ST_BIAS_GO;
      ST_BIAS_GO: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_BIAS_ST;
      end
      ST_BIAS_ST:   state_nxt = (half_r && idx_r == 2'd2) ? ST_BOND_GO : ST_BIAS_MUL;
      ST_E_MUL:     state_nxt = ST_E_MUL2;
      ST_E_MUL2:    state_nxt = ST_E_FIN;
      ST_E_FIN:     state_nxt = ST_PUSH;
      ST_PUSH:      if (push_ok) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // unit controls and operand selection
  always_comb begin
    div_req  = '0;
    div_num  = '0;
    div_den  = box_r[idx_r];
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_BOND_GO: begin
        div_req.start = 1'b1;
        div_num       = 64'(p0_r[idx_r]) - 64'(p1_r[idx_r]);
      end
      ST_BOND_SQ: begin
        mul_a = div_wrp;
        mul_b = div_wrp;
      end
      ST_SQRT_GO: sq_start = 1'b1;
      ST_F0_GO: begin
        div_req = '{start: 1'b1, wide: 1'b1};
        div_num = u_num;
        div_den = width_r;
      end
      ST_F0_SQ: begin
        mul_a = div_quo;
        mul_b = div_quo;
      end
      ST_S_MUL1: begin
        mul_a = hs;
        mul_b = f0_r;
      end
      ST_S_MUL2: begin
        mul_a = pr_q;
        mul_b = f1_r;
      end
      ST_S_DIV: begin
        div_req = '{start: 1'b1, wide: 1'b1};
        div_num = s4_num;
        div_den = width_r;
      end
      ST_FORCE_MUL: begin
        mul_a = b_r[idx_r];
        mul_b = s_r;
      end
      ST_FORCE_GO: begin
        div_req = '{start: 1'b1, wide: 1'b1};
        div_num = prod_r;
        div_den = d_r;
      end
      ST_UPD_D: begin
        mul_a = f_r[idx_r];
        mul_b = $signed({1'b0, dscale_r});
      end
      ST_UPD_N0: begin
        mul_a = v0_r[idx_r];
        mul_b = $signed({1'b0, nscale_r});
      end
      ST_UPD_N1: begin
        mul_a = v1_r[idx_r];
        mul_b = $signed({1'b0, nscale_r});
      end
      ST_UPD_W0, ST_UPD_W1: begin
        div_req.start = 1'b1;
        div_num       = acc_r;
      end
      ST_BIAS_MUL: begin
        mul_a = half_r ? v1_r[idx_r] : v0_r[idx_r];
        mul_b = $signed({1'b0, dscale_r});
      end
      ST_BIAS_GO: begin
        div_req.start = 1'b1;
        div_num       = 64'(half_r ? p1_r[idx_r] : p0_r[idx_r]) + 64'(pr_q);
      end
      ST_E_MUL: begin
        mul_a = f1_r;
        mul_b = f1_r;
      end
      ST_E_MUL2: begin
        mul_a = hs;
        mul_b = pr_q;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    idx_nxt   = idx_r;
    half_nxt  = half_r;
    post_nxt  = post_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    v0_nxt    = v0_r;
    v1_nxt    = v1_r;
    b_nxt     = b_r;
    f_nxt     = f_r;
    sq_nxt    = sq_r;
    d_nxt     = d_r;
    f0_nxt    = f0_r;
    f1_nxt    = f1_r;
    s_nxt     = s_r;
    drift_nxt = drift_r;
    acc_nxt   = acc_r;
    e_nxt     = e_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o0_nxt    = o0_r;
    o1_nxt    = o1_r;
    obond_nxt = obond_r;
    oen_nxt   = oen_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          v0_nxt   = '{in_value_a, in_value_b, in_value_c};
          v1_nxt   = '{in_value_d, in_value_e, in_value_f};
          idx_nxt  = 2'd0;
          half_nxt = 1'b0;
          sq_nxt   = '0;
          post_nxt = (in_req_type != REQ_STEP);
          if (in_req_type == REQ_LOAD) begin
            p0_nxt = '{in_value_a, in_value_b, in_value_c};
            p1_nxt = '{in_value_d, in_value_e, in_value_f};
          end
        end
      end
      ST_BOND_SQ:  b_nxt[idx_r] = div_wrp;
      ST_BOND_ACC: begin
        sq_nxt  = sq_r + $unsigned(prod_r);
        idx_nxt = (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
      end
      ST_SQRT_WAIT: begin
        if (sq_done) begin
          d_nxt = sq_root[31] ? 31'h7fffffff : sq_root[30:0];
          if (!post_r && sq_root == 32'd0) begin
            f_nxt   = '{32'sd0, 32'sd0, 32'sd0};
            idx_nxt = 2'd0;
          end
        end
      end
      ST_F0_SQ:   f0_nxt = div_quo;
      ST_F1:      f1_nxt = sat32(ONE_Q - 64'(pr_q));
      ST_S_STORE: begin
        s_nxt   = div_quo;
        idx_nxt = 2'd0;
      end
      ST_FORCE_ST: begin
        f_nxt[idx_r] = div_quo;
        idx_nxt      = (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
      end
      ST_UPD_N0: drift_nxt = pr_q;
      ST_UPD_N1: acc_nxt = 64'(p0_r[idx_r]) + 64'(drift_r) + 64'(pr_q);
      ST_UPD_W0: acc_nxt = 64'(p1_r[idx_r]) - 64'(drift_r) + 64'(pr_q);
      ST_UPD_W1: p0_nxt[idx_r] = div_wrp;
      ST_UPD_W2: begin
        p1_nxt[idx_r] = div_wrp;
        if (idx_r == 2'd2) begin
          idx_nxt  = 2'd0;
          sq_nxt   = '0;
          post_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      ST_BIAS_ST: begin
        if (half_r) begin
          p1_nxt[idx_r] = div_wrp;
        end else begin
          p0_nxt[idx_r] = div_wrp;
        end
        if (idx_r == 2'd2) begin
          idx_nxt  = 2'd0;
          half_nxt = 1'b1;
          sq_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      ST_E_FIN: e_nxt = pr_q[31] ? 31'd0 : pr_q[30:0];
      ST_PUSH: begin
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          o0_nxt        = p0_r;
          o1_nxt        = p1_r;
          obond_nxt     = d_r;
          oen_nxt       = e_r;
        end
      end
      default: ;
    endcase
  end

  // control state and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
      p0_r        <= '{32'sd0, 32'sd0, 32'sd0};
      p1_r        <= '{32'sd0, 32'sd0, 32'sd0};
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      p0_r        <= p0_nxt;
      p1_r        <= p1_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    half_r  <= half_nxt;
    post_r  <= post_nxt;
    v0_r    <= v0_nxt;
    v1_r    <= v1_nxt;
    b_r     <= b_nxt;
    f_r     <= f_nxt;
    sq_r    <= sq_nxt;
    d_r     <= d_nxt;
    f0_r    <= f0_nxt;
    f1_r    <= f1_nxt;
    s_r     <= s_nxt;
    drift_r <= drift_nxt;
    acc_r   <= acc_nxt;
    e_r     <= e_nxt;
    prod_r  <= mul_p;
    o0_r    <= o0_nxt;
    o1_r    <= o1_nxt;
    obond_r <= obond_nxt;
    oen_r   <= oen_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r    <= '{RST_BOX, RST_BOX, RST_BOX};
      height_r <= RST_HEIGHT;
      rest_r   <= RST_REST;
      width_r  <= RST_WIDTH;
      dscale_r <= RST_DRIFT;
      nscale_r <= RST_NOISE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_X:       box_r[0] <= cfg_data;
        REG_BOX_Y:       box_r[1] <= cfg_data;
        REG_BOX_Z:       box_r[2] <= cfg_data;
        REG_WELL_HEIGHT: height_r <= cfg_data;
        REG_REST_LENGTH: rest_r   <= cfg_data;
        REG_WELL_WIDTH:  width_r  <= cfg_data;
        REG_DRIFT_SCALE: dscale_r <= cfg_data;
        REG_NOISE_SCALE: nscale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_x     = o0_r[0];
  assign out_first_y     = o0_r[1];
  assign out_first_z     = o0_r[2];
  assign out_second_x    = o1_r[0];
  assign out_second_y    = o1_r[1];
  assign out_second_z    = o1_r[2];
  assign out_bond_length = obond_r;
  assign out_energy      = oen_r;

endmodule
`default_nettype wire

FILE: sv/dbd_div.sv
// Bit-serial signed divider with round-half-away quotient and wrap remainder.
`default_nettype none
module dbd_div import dbd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire div_req_t           req,
  input  wire logic signed [63:0] num,
  input  wire logic [30:0]        den,
  output logic                    done,
  output logic signed [31:0]      quo,
  output logic signed [31:0]      wrp
);

  logic              busy_r, done_r, neg_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] num_r, q_r;
  logic [31:0]       rem_r;
  logic [30:0]       den_r;

  logic [63:0]        mag;
  logic [31:0]        rem_sh, rem_sub;
  logic               ge, rup;
  logic [63:0]        qmag;
  logic signed [63:0] qs;
  logic signed [31:0] dm;

  assign mag     = num[63] ? (~num + 64'd1) : num;
  assign rem_sh  = {rem_r[30:0], num_r[DIV_NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.wide ? DIV_CW'(DIV_NW) : DIV_CW'(DIV_NN);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CW'(1);
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= num[63];
      den_r <= (den == 31'd0) ? 31'd1 : den;
      num_r <= req.wide ? mag[DIV_NW-1:0] : {mag[DIV_NN-1:0], {(DIV_NW-DIV_NN){1'b0}}};
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub : rem_sh;
      q_r   <= {q_r[DIV_NW-2:0], ge};
      num_r <= {num_r[DIV_NW-2:0], 1'b0};
    end
  end

  // round half away: bump when twice the remainder reaches the divisor
  assign rup  = {rem_r[30:0], 1'b0} >= {1'b0, den_r};
  assign qmag = {{(64-DIV_NW){1'b0}}, q_r} + {63'd0, rup};
  assign qs   = neg_r ? -$signed(qmag) : $signed(qmag);
  assign dm   = rup ? ($signed({1'b0, rem_r[30:0]}) - $signed({1'b0, den_r}))
                    : $signed({1'b0, rem_r[30:0]});

  assign done = done_r;
  assign quo  = sat32(qs);
  assign wrp  = neg_r ? -dm : dm;

endmodule
`default_nettype wire

FILE: sv/dbd_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
`default_nettype none
module dbd_sqrt import dbd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] n,
  output logic             done,
  output logic [31:0]      root
);

  logic        busy_r, done_r;
  logic [63:0] n_r, res_r, bit_r;
  logic [63:0] trial;
  logic        ge;

  assign trial = res_r + bit_r;
  assign ge    = n_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n;
      res_r <= '0;
      bit_r <= 64'd1 << SQRT_TOP;
    end else if (busy_r) begin
      if (ge) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule
`default_nettype wire

FILE: verif/dimer_brownian_dynamics_step_core_tb.sv
// Self-checking testbench for the dimer Brownian dynamics step core.
`timescale 1ns / 1ps
`default_nettype none
module dimer_brownian_dynamics_step_core_tb import dbd_pkg::*; ();

  // Request type three is not a package code: it only reports the current state.
  localparam logic [1:0] REQ_QUERY = 2'd3;
  localparam longint ONE_Q = 64'sd65536;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam int RAND_ITEMS = 100;

  typedef struct packed {
    logic [5:0][31:0] pos;
    logic [30:0]      bond;
    logic [30:0]      energy;
  } dimer_res_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [5:0][31:0] vals;
    logic             typed;
    dimer_res_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = REQ_STEP;
  logic signed [31:0] in_value_a = '0, in_value_b = '0, in_value_c = '0;
  logic signed [31:0] in_value_d = '0, in_value_e = '0, in_value_f = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_first_x, out_first_y, out_first_z;
  logic signed [31:0] out_second_x, out_second_y, out_second_z;
  logic [30:0] out_bond_length, out_energy;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_BOX_X;
  logic [30:0] cfg_data = '0;

  always #5 clk = ~clk;

  dimer_brownian_dynamics_step_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_value_a(in_value_a), .in_value_b(in_value_b), .in_value_c(in_value_c),
    .in_value_d(in_value_d), .in_value_e(in_value_e), .in_value_f(in_value_f),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_first_x(out_first_x), .out_first_y(out_first_y), .out_first_z(out_first_z),
    .out_second_x(out_second_x), .out_second_y(out_second_y),
    .out_second_z(out_second_z),
    .out_bond_length(out_bond_length), .out_energy(out_energy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers and particle coordinates, 64-bit arithmetic
  // ---------------------------------------------------------------------------
  logic [30:0] reg_shadow[8];
  longint      coord[6];
  dimer_res_t  pending_res[$];
  int          errs = 0;
  bit          idle_gaps = 1'b1;   // both sides draw random gaps while set

  function automatic longint clip32(longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  // Round half away from zero; den is positive.
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q, r;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = mag / den;
    r = mag % den;
    if (r >= den - r) q++;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clip32(round_div(a * b, ONE_Q));
  endfunction

  function automatic longint fx_div(longint a, longint unsigned b);
    return clip32(round_div(a * ONE_Q, b));
  endfunction

  // A zero register behaves as one raw unit.
  function automatic longint unsigned reg_len(int k);
    return (reg_shadow[k] == 0) ? 64'd1 : longint'(reg_shadow[k]);
  endfunction

  function automatic longint wrap_box(longint v, longint unsigned len);
    return v - round_div(v, len) * longint'(len);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bt;
    root = 0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= root + bt) begin
        n -= root + bt;
        root = (root >> 1) + bt;
      end else begin
        root >>= 1;
      end
      bt >>= 2;
    end
    return root;
  endfunction

  // Minimum-image vector from particle 1 to particle 0, and its length.
  function automatic longint bond_vec(output longint b[3]);
    longint unsigned sq;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      b[i] = wrap_box(coord[i] - coord[3 + i], reg_len(i));
      sq += longint'(b[i] * b[i]);
    end
    return longint'(int_sqrt(sq));
  endfunction

  function automatic void well_terms(input longint d, output longint f0, output longint f1);
    longint u;
    u = d - longint'(reg_shadow[REG_REST_LENGTH]) - longint'(reg_shadow[REG_WELL_WIDTH]);
    f0 = fx_div(u, reg_len(REG_WELL_WIDTH));
    f1 = clip32(ONE_Q - fx_mul(f0, f0));
  endfunction

  function automatic dimer_res_t advance_dimer(logic [1:0] kind, logic [5:0][31:0] v);
    longint val[6], b[3], frc[3];
    longint d, f0, f1, s, e, drift;
    dimer_res_t r;
    for (int i = 0; i < 6; i++) val[i] = longint'($signed(v[i]));
    case (kind)
      REQ_STEP: begin
        frc = '{0, 0, 0};
        d = bond_vec(b);
        // zero distance: no force
        if (d != 0) begin
          well_terms(d, f0, f1);
          s = fx_mul(longint'(reg_shadow[REG_WELL_HEIGHT]), f0);
          s = fx_mul(s, f1);
          s = clip32(4 * s);
          s = fx_div(s, reg_len(REG_WELL_WIDTH));
          for (int i = 0; i < 3; i++) frc[i] = clip32(round_div(b[i] * s, d));
        end
        for (int i = 0; i < 3; i++) begin
          drift = fx_mul(frc[i], longint'(reg_shadow[REG_DRIFT_SCALE]));
          coord[i] = wrap_box(coord[i] + drift +
                              fx_mul(val[i], longint'(reg_shadow[REG_NOISE_SCALE])),
                              reg_len(i));
          coord[3 + i] = wrap_box(coord[3 + i] - drift +
                                  fx_mul(val[3 + i], longint'(reg_shadow[REG_NOISE_SCALE])),
                                  reg_len(i));
        end
      end
      REQ_BIAS: begin
        for (int i = 0; i < 6; i++)
          coord[i] = wrap_box(coord[i] + fx_mul(val[i], longint'(reg_shadow[REG_DRIFT_SCALE])),
                              reg_len(i % 3));
      end
      REQ_LOAD: begin
        // loaded coordinates are not wrapped
        for (int i = 0; i < 6; i++) coord[i] = val[i];
      end
      default: begin
      end
    endcase
    d = bond_vec(b);
    well_terms(d, f0, f1);
    e = fx_mul(longint'(reg_shadow[REG_WELL_HEIGHT]), fx_mul(f1, f1));
    if (e < 0) e = 0;
    if (e > S32_HI) e = S32_HI;
    if (d > S32_HI) d = S32_HI;
    for (int i = 0; i < 6; i++) r.pos[i] = coord[i][31:0];
    r.bond = d[30:0];
    r.energy = e[30:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request after a random gap (if idle_gaps); hold it until taken, then
  // record the expected result. A typed row overrides the predicted result.
  task automatic send_request(logic [1:0] kind, logic [5:0][31:0] v, logic typed,
                              dimer_res_t typed_res);
    int gap;
    dimer_res_t r;
    gap = idle_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_value_a <= v[0];
    in_value_b <= v[1];
    in_value_c <= v[2];
    in_value_d <= v[3];
    in_value_e <= v[4];
    in_value_f <= v[5];
    do @(posedge clk); while (!(in_valid && in_ready));
    r = advance_dimer(kind, v);
    pending_res.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    // every request answers, so only a short settle is needed
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    reg_shadow[idx] = val;
    @(posedge clk);
  endtask

  task automatic load_config(logic [30:0] bx, logic [30:0] by, logic [30:0] bz,
                             logic [30:0] h, logic [30:0] r0, logic [30:0] w,
                             logic [30:0] dr, logic [30:0] nz);
    set_reg(REG_BOX_X, bx);
    set_reg(REG_BOX_Y, by);
    set_reg(REG_BOX_Z, bz);
    set_reg(REG_WELL_HEIGHT, h);
    set_reg(REG_REST_LENGTH, r0);
    set_reg(REG_WELL_WIDTH, w);
    set_reg(REG_DRIFT_SCALE, dr);
    set_reg(REG_NOISE_SCALE, nz);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    // mostly deviate-sized values, some anywhere in the 32-bit range
    if (pick < 7) return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
    return $urandom();
  endfunction

  task automatic random_phase(int count);
    logic [5:0][31:0] v;
    logic [1:0] kind;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 50) ? REQ_STEP : (pick < 70) ? REQ_BIAS :
             (pick < 90) ? REQ_LOAD : REQ_QUERY;
      for (int i = 0; i < 6; i++) v[i] = rand_value();
      send_request(kind, v, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t mk_row(logic [1:0] kind, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] c, logic [31:0] d, logic [31:0] e,
                                       logic [31:0] f);
    stim_row_t row;
    row = '0;
    row.kind = kind;
    row.vals = {f, e, d, c, b, a};
    return row;
  endfunction

  function automatic stim_row_t mk_typed(stim_row_t row, logic [5:0][31:0] pos,
                                         logic [30:0] bond, logic [30:0] energy);
    row.typed = 1'b1;
    row.res.pos = pos;
    row.res.bond = bond;
    row.res.energy = energy;
    return row;
  endfunction

  stim_row_t dir_tab[$];

  initial begin
    stim_row_t row;
    reg_shadow = '{RST_BOX, RST_BOX, RST_BOX, RST_HEIGHT, RST_REST, RST_WIDTH,
                   RST_DRIFT, RST_NOISE};
    coord = '{0, 0, 0, 0, 0, 0};

    // At rest both particles sit at the origin: f0 = -3, f1 = -8, energy 64.
    row = mk_row(REQ_QUERY, 0, 0, 0, 0, 0, 0);
    dir_tab.push_back(mk_typed(row, '0, 31'd0, 31'd4194304));
    // bond of 1.0 is the compact minimum: zero energy
    row = mk_row(REQ_LOAD, 32'd65536, 0, 0, 0, 0, 0);
    dir_tab.push_back(mk_typed(row, row.vals, 31'd65536, 31'd0));
    dir_tab.push_back(mk_row(REQ_STEP, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_STEP, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    dir_tab.push_back(mk_row(REQ_STEP, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000));
    dir_tab.push_back(mk_row(REQ_BIAS, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    dir_tab.push_back(mk_row(REQ_BIAS, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000));
    // unwrapped extreme coordinates
    row = mk_row(REQ_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000);
    dir_tab.push_back(row);
    dir_tab.push_back(mk_row(REQ_QUERY, 32'h5a5a5a5a, 32'h5a5a5a5a, 32'h5a5a5a5a,
                             32'h5a5a5a5a, 32'h5a5a5a5a, 32'h5a5a5a5a));
    dir_tab.push_back(mk_row(REQ_STEP, 0, 0, 0, 0, 0, 0));
    // coincident particles: zero distance, no force, positions stay on a quiet step
    row = mk_row(REQ_LOAD, 12345, -12345, 777, 12345, -12345, 777);
    dir_tab.push_back(mk_typed(row, row.vals, 31'd0, 31'd4194304));
    row = mk_row(REQ_STEP, 0, 0, 0, 0, 0, 0);
    dir_tab.push_back(mk_typed(row, dir_tab[$].vals, 31'd0, 31'd4194304));
    // bond of 2.0 is the stretched minimum
    row = mk_row(REQ_LOAD, 32'd131072, 0, 0, 0, 0, 0);
    dir_tab.push_back(mk_typed(row, row.vals, 31'd131072, 31'd0));
    dir_tab.push_back(mk_row(REQ_STEP, 32'd65536, -32'sd131072, 32'd98304,
                             -32'sd65536, 32'd20000, -32'sd200000));
    dir_tab.push_back(mk_row(REQ_BIAS, 32'd1000000, -32'sd3000000, 32'd12,
                             -32'sd1, 32'd5000000, -32'sd7000000));
    dir_tab.push_back(mk_row(REQ_LOAD, -32'sd327680, 32'd327680, -32'sd1,
                             32'd327679, -32'sd300000, 32'd65536));
    dir_tab.push_back(mk_row(REQ_STEP, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                             32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));
    dir_tab.push_back(mk_row(REQ_QUERY, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                             32'hffffffff, 32'hffffffff, 32'hffffffff));
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases on reset and new settings
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) send_request(dir_tab[k].kind, dir_tab[k].vals,
                                      dir_tab[k].typed, dir_tab[k].res);
    random_phase(RAND_ITEMS);
    drain_results();

    // widest settings
    load_config({31{1'b1}}, {31{1'b1}}, {31{1'b1}}, {31{1'b1}}, {31{1'b1}},
                {31{1'b1}}, {31{1'b1}}, {31{1'b1}});
    idle_gaps = 1'b0;
    random_phase(RAND_ITEMS);
    drain_results();

    // narrowest settings: unit boxes, no barrier, no drift, no noise
    load_config(31'd1, 31'd1, 31'd1, 31'd0, 31'd0, 31'd1, 31'd0, 31'd0);
    idle_gaps = 1'b1;
    random_phase(RAND_ITEMS / 2);
    drain_results();

    // physical-looking settings drawn at random
    for (int p = 0; p < 3; p++) begin
      load_config(31'($urandom_range(65536, 40 * 65536)),
                  31'($urandom_range(65536, 40 * 65536)),
                  (p == 2) ? 31'($urandom()) : 31'($urandom_range(1, 40 * 65536)),
                  31'($urandom_range(0, 8 * 65536)), 31'($urandom_range(0, 4 * 65536)),
                  31'($urandom_range(1, 2 * 65536)), 31'($urandom_range(0, 4096)),
                  (p == 1) ? 31'($urandom()) : 31'($urandom_range(0, 32768)));
      idle_gaps = (p != 1);
      random_phase(RAND_ITEMS + 10);
      drain_results();
    end

    if (errs == 0) begin
      $display("dimer_brownian_dynamics_step_core_tb: done, clean");
    end else begin
      $display("dimer_brownian_dynamics_step_core_tb: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off, field-by-field compare
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      if (errs <= 10)
        $display("mismatch %s: expected %h, got %h at %0t", name, exp_v, act_v, $realtime);
    end
  endtask

  initial begin
    int stall;
    int taken;
    dimer_res_t want;
    taken = 0;
    @(posedge rst_n);
    forever begin
      stall = idle_gaps ? $urandom_range(0, 14) : 0;
      // hold off long enough for the sender to pile up behind a full block
      if (taken == 150) stall = 4000;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
      if (pending_res.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_res.pop_front();
        check_field("first_x", want.pos[0], out_first_x);
        check_field("first_y", want.pos[1], out_first_y);
        check_field("first_z", want.pos[2], out_first_z);
        check_field("second_x", want.pos[3], out_second_x);
        check_field("second_y", want.pos[4], out_second_y);
        check_field("second_z", want.pos[5], out_second_z);
        check_field("bond_length", {1'b0, want.bond}, {1'b0, out_bond_length});
        check_field("energy", {1'b0, want.energy}, {1'b0, out_energy});
      end
    end
  end

  // Run limit: ends the run with an error report if the sequence has not finished.
  initial begin
    #60_000_000;
    $display("dimer_brownian_dynamics_step_core_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
sv/dbd_pkg.sv
sv/dbd_div.sv
sv/dbd_sqrt.sv
sv/dimer_brownian_dynamics_step_core.sv
verif/dimer_brownian_dynamics_step_core_tb.sv
